// ----- sv/signed_binary_to_decimal_ascii_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// same-cycle implication
`define SBDAC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SBDAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/sbdac_pkg.sv -----
// ---------------------------------------------------------------------------
// sbdac_pkg
// Shared constants, types and helpers of the decimal ASCII converter.
// ---------------------------------------------------------------------------
package sbdac_pkg;

   localparam int VALUE_BITS_DEF  = 32;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int NUMBER_BITS     = 32;
   localparam int CHAR_BITS       = 6;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;

   // queue status seen by the front and back parts
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // decimal digits needed for a bits-wide unsigned value: floor(bits*log10(2)) + 1
   function automatic int digit_count(input int bits);
      return (bits * 30103) / 100000 + 1;
   endfunction

endpackage

// ----- sv/sbdac_queue.sv -----
// ---------------------------------------------------------------------------
// sbdac_queue
// Short register queue between the classifying front and the converting back.
// ---------------------------------------------------------------------------
module sbdac_queue #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       push_data,
   input  logic                   pop,
   output logic [WIDTH-1:0]       pop_data,
   output sbdac_pkg::q_stat_type  q_stat
);
   import sbdac_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_BITS'(DEPTH));
   assign q_stat.empty = (count_ff == '0);

endmodule

// ----- sv/sbdac_front.sv -----
// ---------------------------------------------------------------------------
// sbdac_front
// Takes requests, splits each number into sign and unsigned magnitude.
// ---------------------------------------------------------------------------
module sbdac_front #(
   parameter int VALUE_BITS = 32
) (
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [sbdac_pkg::NUMBER_BITS-1:0] req_number,
   input  sbdac_pkg::q_stat_type                    q_stat,
   output logic                                     push,
   output logic [VALUE_BITS:0]                      push_data
);
   import sbdac_pkg::*;

   localparam int WIDE_BITS = (VALUE_BITS > NUMBER_BITS) ? VALUE_BITS : NUMBER_BITS;

   logic [WIDE_BITS-1:0]  wide;
   logic [VALUE_BITS-1:0] value;
   logic                  negative;
   logic [VALUE_BITS-1:0] magnitude;

   always_comb begin
      // bits above VALUE_BITS are ignored
      wide      = WIDE_BITS'($unsigned(req_number));
      value     = wide[VALUE_BITS-1:0];
      negative  = value[VALUE_BITS-1];
      // most negative value comes out as its full unsigned magnitude
      magnitude = negative ? (~value + VALUE_BITS'(1)) : value;
   end

   assign req_ready = !q_stat.full;
   assign push      = req_valid && !q_stat.full;
   assign push_data = {negative, magnitude};

endmodule

// ----- sv/sbdac_back.sv -----
// ---------------------------------------------------------------------------
// sbdac_back
// Bit-serial double dabble, then one digit per cycle unless stalled.
// ---------------------------------------------------------------------------
`include "signed_binary_to_decimal_ascii_core_macros.svh"

module sbdac_back #(
   parameter int VALUE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sbdac_pkg::q_stat_type               q_stat,
   input  logic [VALUE_BITS:0]                 pop_data,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sbdac_pkg::CHAR_BITS-1:0]     rsp_char_code,
   output logic                                rsp_last
);
   import sbdac_pkg::*;

   localparam int NUM_DIGITS = digit_count(VALUE_BITS);
   localparam int BCD_BITS   = 4 * NUM_DIGITS;
   localparam int CNT_BITS   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int DL_BITS    = $clog2(NUM_DIGITS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_SIGN  = 3'd2;
   localparam logic [2:0] ST_SKIP  = 3'd3;
   localparam logic [2:0] ST_DIGIT = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [CNT_BITS-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DL_BITS-1:0]    dig_left_ff, dig_left_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]  rsp_char_code_ff, rsp_char_code_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [BCD_BITS-1:0]   bcd_adj;
   logic [3:0]            top_digit;
   logic                  slot_free;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ?
                             bcd_ff[4*i +: 4] + 4'd3 : bcd_ff[4*i +: 4];
      end
   end

   assign top_digit = bcd_ff[BCD_BITS-1 -: 4];
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in         = state_ff;
      mag_in           = mag_ff;
      neg_in           = neg_ff;
      bcd_in           = bcd_ff;
      bit_cnt_in       = bit_cnt_ff;
      dig_left_in      = dig_left_ff;
      pop              = 1'b0;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_char_code_in = rsp_char_code_ff;
      rsp_last_in      = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               pop         = 1'b1;
               neg_in      = pop_data[VALUE_BITS];
               mag_in      = pop_data[VALUE_BITS-1:0];
               bcd_in      = '0;
               bit_cnt_in  = CNT_BITS'(VALUE_BITS - 1);
               dig_left_in = DL_BITS'(NUM_DIGITS);
               state_in    = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in     = {bcd_adj[BCD_BITS-2:0], mag_ff[VALUE_BITS-1]};
            mag_in     = mag_ff << 1;
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               state_in = neg_ff ? ST_SIGN : ST_SKIP;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_char_code_in = CHAR_MINUS;
               rsp_last_in      = 1'b0;
               state_in         = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, always keep the units digit
            if (top_digit == 4'd0 && dig_left_ff != DL_BITS'(1)) begin
               bcd_in      = bcd_ff << 4;
               dig_left_in = dig_left_ff - 1'b1;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_char_code_in = CHAR_ZERO + {2'b00, top_digit};
               rsp_last_in      = (dig_left_ff == DL_BITS'(1));
               bcd_in           = bcd_ff << 4;
               dig_left_in      = dig_left_ff - 1'b1;
               if (dig_left_ff == DL_BITS'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff           <= mag_in;
      neg_ff           <= neg_in;
      bcd_ff           <= bcd_in;
      bit_cnt_ff       <= bit_cnt_in;
      dig_left_ff      <= dig_left_in;
      rsp_char_code_ff <= rsp_char_code_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_code_ff;
   assign rsp_last      = rsp_last_ff;

   `SBDAC_ASSERT_NOW(a_pop_not_empty, pop, !q_stat.empty, "pop from empty queue")
   `SBDAC_ASSERT_NEXT(a_conv_holds, state_ff == ST_CONV && bit_cnt_ff != '0, state_ff == ST_CONV, "conversion ended early")
   `SBDAC_ASSERT_NOW(a_digit_left, state_ff == ST_DIGIT || state_ff == ST_SKIP, dig_left_ff != '0, "no digit left to send")
   `SBDAC_ASSERT_NOW(a_minus_not_last, rsp_valid_ff && rsp_char_code_ff == CHAR_MINUS, !rsp_last_ff, "minus sign flagged last")

endmodule

// ----- sv/signed_binary_to_decimal_ascii_core.sv -----
// ---------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_core
// Signed integer in, decimal ASCII text out, one character per response.
// ---------------------------------------------------------------------------
//  channel   ports                                  carries
//  request   req_valid req_ready req_number         one signed number
//  response  rsp_valid rsp_ready rsp_char_code      one character, last flag
//            rsp_last
//
//  per number: the double dabble shift takes one bit per cycle, then leading
//  zero skipping and sending go one digit a cycle, sending while not stalled;
//  a minus sign adds the sign state before the zero skipping.
//  reset is synchronous and clears the queue, sequencer and response valid.
//  a stalled response holds the back end; the front keeps taking requests
//  until its queue is full.
module signed_binary_to_decimal_ascii_core #(
   parameter int VALUE_BITS  = sbdac_pkg::VALUE_BITS_DEF,
   parameter int QUEUE_DEPTH = sbdac_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [sbdac_pkg::NUMBER_BITS-1:0] req_number,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [sbdac_pkg::CHAR_BITS-1:0]          rsp_char_code,
   output logic                                     rsp_last
);
   import sbdac_pkg::*;

   q_stat_type          q_stat;
   logic                push;
   logic                pop;
   logic [VALUE_BITS:0] push_data;
   logic [VALUE_BITS:0] pop_data;

   sbdac_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_number (req_number),
      .q_stat     (q_stat),
      .push       (push),
      .push_data  (push_data)
   );

   sbdac_queue #(
      .WIDTH (VALUE_BITS + 1),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   sbdac_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (q_stat),
      .pop_data      (pop_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule

// ----- bench/signed_binary_to_decimal_ascii_core_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_core_test
// Sends signed 32-bit numbers to the converter and checks every returned
// character and last flag against a locally computed decimal rendering.
// Directed extremes first, then random numbers with and without idle gaps.
// ---------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_core_test;

   import sbdac_pkg::*;

   typedef struct packed {
      logic [CHAR_BITS-1:0] code;
      logic                 is_last;
   } text_char_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [NUMBER_BITS-1:0] req_number;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [CHAR_BITS-1:0]          rsp_char_code;
   logic                          rsp_last;

   text_char_type pending_chars[$];
   int            numbers_sent;
   int            chars_checked;
   int            mismatch_count;
   int            negatives_sent;
   bit            source_steady;
   bit            sink_steady;

   signed_binary_to_decimal_ascii_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_number    (req_number),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("%0t: timeout, %0d characters still expected", $time, pending_chars.size());
      $display("*** FAILED ***");
      $finish;
   end

   // mostly short idle spans, now and then a long one
   function automatic int pick_idle_len();
      if ($urandom_range(0, 9) < 8) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // decimal text of one number, most significant character first
   function automatic void queue_decimal_text(input logic signed [NUMBER_BITS-1:0] n);
      logic [NUMBER_BITS-1:0] mag;
      logic [3:0]             digs[12];
      int                     nd;
      int                     i;
      text_char_type          c;
      mag = n[NUMBER_BITS-1] ? (~$unsigned(n) + 1'b1) : $unsigned(n);
      nd = 0;
      if (mag == 0) begin
         c.code    = CHAR_ZERO;
         c.is_last = 1'b1;
         pending_chars.push_back(c);
         return;
      end
      while (mag != 0) begin
         digs[nd] = 4'(mag % 10);
         mag      = mag / 10;
         nd++;
      end
      if (n[NUMBER_BITS-1]) begin
         c.code    = CHAR_MINUS;
         c.is_last = 1'b0;
         pending_chars.push_back(c);
      end
      for (i = nd - 1; i >= 0; i--) begin
         c.code    = CHAR_ZERO + CHAR_BITS'(digs[i]);
         c.is_last = (i == 0);
         pending_chars.push_back(c);
      end
   endfunction

   function automatic logic signed [NUMBER_BITS-1:0] pick_number();
      longint lo;
      longint hi;
      longint m;
      int     k;
      int     t;
      case ($urandom_range(0, 3))
         0: begin
            return $urandom;
         end
         1: begin
            // pick a digit count first so short and long runs both show up
            k  = $urandom_range(1, 10);
            lo = 1;
            repeat (k - 1) lo = lo * 10;
            hi = lo * 10 - 1;
            if (hi > 64'sd2147483647) hi = 64'sd2147483647;
            if (k == 1) lo = 0;
            m = lo + longint'($urandom) % (hi - lo + 1);
            if ($urandom_range(0, 1)) m = -m;
            return NUMBER_BITS'(m);
         end
         2: begin
            t = $urandom_range(0, 40);
            return t - 20;
         end
         default: begin
            t = $urandom_range(0, 15);
            if ($urandom_range(0, 1)) begin
               return 32'sh7fff_ffff - t;
            end
            return 32'sh8000_0000 + t;
         end
      endcase
   endfunction

   task automatic send_number(input logic signed [NUMBER_BITS-1:0] n);
      int gap;
      gap = (source_steady || $urandom_range(0, 1)) ? 0 : pick_idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_number <= n;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      queue_decimal_text(n);
      numbers_sent++;
      if (n < 0) negatives_sent++;
      @(negedge clock);
   endtask

   // response side: alternating ready and stall runs unless held steady
   initial begin
      int run_left;
      bit run_ready;
      rsp_ready = 1'b0;
      run_left  = 0;
      run_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_steady) begin
            rsp_ready <= 1'b1;
         end else begin
            if (run_left == 0) begin
               run_ready = ~run_ready;
               run_left  = run_ready ? $urandom_range(1, 12) : pick_idle_len();
            end
            run_left--;
            rsp_ready <= run_ready;
         end
      end
   end

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected character, got code %0d last %0b", $time,
                     rsp_char_code, rsp_last);
            mismatch_count++;
         end else begin
            want = pending_chars.pop_front();
            chars_checked++;
            if (rsp_char_code !== want.code) begin
               $display("%0t: char_code mismatch, expected %0d got %0d", $time,
                        want.code, rsp_char_code);
               mismatch_count++;
            end
            if (rsp_last !== want.is_last) begin
               $display("%0t: last mismatch, expected %0b got %0b", $time,
                        want.is_last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_directed();
      logic signed [NUMBER_BITS-1:0] numbers[$];
      numbers = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
                  32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0001, 32'sh7fff_fffe,
                  1000000000, -1000000000, 999999999, -999999999,
                  123456789, -987654321, 32'sh5555_5555, 32'shaaaa_aaaa, 0};
      foreach (numbers[i]) send_number(numbers[i]);
   endtask

   // back to back requests with the response side always ready
   task automatic test_random_steady();
      source_steady = 1'b1;
      sink_steady   = 1'b1;
      repeat (30) send_number(pick_number());
      source_steady = 1'b0;
      sink_steady   = 1'b0;
   endtask

   task automatic test_random_idling();
      repeat (77) send_number(pick_number());
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_number     = '0;
      source_steady  = 1'b0;
      sink_steady    = 1'b0;
      numbers_sent   = 0;
      chars_checked  = 0;
      mismatch_count = 0;
      negatives_sent = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random_steady();
      test_random_idling();

      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("converted %0d numbers (%0d negative), checked %0d characters",
               numbers_sent, negatives_sent, chars_checked);
      $display("extremes, zero and random digit counts with idle gaps on both sides");
      if (mismatch_count == 0 && pending_chars.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/sbdac_pkg.sv
sv/sbdac_queue.sv
sv/sbdac_front.sv
sv/sbdac_back.sv
sv/signed_binary_to_decimal_ascii_core.sv
bench/signed_binary_to_decimal_ascii_core_test.sv
